FILE: hdl/tcce_pkg.sv
// Shared types, codes and constants of the text console cursor engine.
package tcce_pkg;

	localparam int GLYPH_WIDTH      = 9;
	localparam int GLYPH_HEIGHT     = 16;
	localparam int GLYPH_X_OFFSET   = 7;
	localparam int TAB_SPACES_DEF   = 4;
	localparam int MAX_RESULTS      = 8;

	localparam logic [7:0] CTRL_TEXT_COLUMNS = 8'd80;
	localparam logic [7:0] CTRL_TEXT_ROWS    = 8'd25;

	localparam logic OP_PUT_CHAR     = 1'b0;
	localparam logic OP_CLEAR_SCREEN = 1'b1;

	localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
	localparam logic [7:0] CHAR_TAB       = 8'd9;
	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [7:0] CHAR_RETURN    = 8'd13;
	localparam logic [7:0] CHAR_SPACE     = 8'd32;

	typedef enum logic [1:0] {
		CMD_GLYPH  = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_SCROLL = 2'd2,
		CMD_FILL   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_TEXT_COLUMNS     = 2'd0,
		CFG_TEXT_ROWS        = 2'd1,
		CFG_BACKGROUND_COLOR = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  char_code;
		logic [23:0] fg_color;
	} item_t;

	typedef struct packed {
		cmd_t        command;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [7:0]  glyph_code;
		logic [23:0] draw_color;
	} result_t;

	// one step of the cursor sequencer
	typedef struct packed {
		logic        emit;
		logic        done;
		logic        glyph_pending;
		logic        next_space;
		logic [8:0]  col;
		logic [7:0]  row;
		result_t     res;
	} step_t;

endpackage

FILE: hdl/tcce_step.sv
// Cursor step logic: next cursor position and the command of one sequencer step.
module tcce_step import tcce_pkg::*; (
	input  item_t       item,
	input  logic        glyph_pending,
	input  logic        last_space,
	input  logic [8:0]  col,
	input  logic [7:0]  row,
	input  logic [7:0]  text_columns,
	input  logic [7:0]  text_rows,
	input  logic [23:0] background_color,
	output step_t       step
);

	logic [8:0] adv_col;
	logic [7:0] adv_row;
	logic [7:0] adv_row_c;
	logic       adv_scroll;
	logic [8:0] bs_col;
	logic [7:0] bs_row;
	logic [8:0] g_col;
	logic [7:0] g_row;
	logic       is_tab;

	function automatic logic [11:0] pix_x(input logic [8:0] c);
		logic [11:0] prod;
		prod = 12'({3'b000, c} * 12'(GLYPH_WIDTH));
		return prod - 12'(GLYPH_X_OFFSET);
	endfunction

	function automatic logic [11:0] pix_y(input logic [7:0] r);
		return 12'({4'b0000, r} * 12'(GLYPH_HEIGHT));
	endfunction

	always_comb begin
		// advance: wrap once the column has passed the column count
		if (col > {1'b0, text_columns}) begin
			adv_col = '0;
			adv_row = row + 8'd1;
		end else begin
			adv_col = col + 9'd1;
			adv_row = row;
		end
		adv_scroll = (adv_row >= text_rows);
		if (adv_scroll) begin
			adv_row_c = (text_rows != 8'd0) ? text_rows - 8'd1 : 8'd0;
		end else begin
			adv_row_c = adv_row;
		end

		// backspace step-back with its odd wrap rule
		bs_col = col - 9'd1;
		bs_row = row;
		if (bs_col == 9'd0) begin
			bs_col = (text_columns != 8'd0) ? {1'b0, text_columns} - 9'd1 : 9'd0;
			if (row != 8'd0) begin
				bs_row = row - 8'd1;
			end
			if (bs_row == 8'd0) begin
				bs_col = '0;
				bs_row = '0;
			end
		end

		g_col  = glyph_pending ? col : adv_col;
		g_row  = glyph_pending ? row : adv_row_c;
		is_tab = (item.char_code == CHAR_TAB);

		step                = '0;
		step.col            = col;
		step.row            = row;
		step.res.command    = CMD_GLYPH;
		step.res.draw_color = background_color;

		if (item.opcode == OP_CLEAR_SCREEN) begin
			step.emit        = 1'b1;
			step.done        = 1'b1;
			step.res.command = CMD_FILL;
			step.col         = '0;
			step.row         = '0;
		end else if (item.char_code == CHAR_NEWLINE) begin
			step.emit        = adv_scroll;
			step.done        = 1'b1;
			step.res.command = CMD_SCROLL;
			step.col         = '0;
			step.row         = adv_row_c + 8'd1;
		end else if (item.char_code == CHAR_RETURN) begin
			step.done = 1'b1;
			step.col  = '0;
		end else if (item.char_code == CHAR_BACKSPACE && col != 9'd0 && !glyph_pending) begin
			// a backspace drawn as a glyph has already advanced the column
			step.emit        = 1'b1;
			step.done        = 1'b1;
			step.res.command = CMD_CLEAR;
			step.res.pixel_x = pix_x(bs_col + 9'd1);
			step.res.pixel_y = pix_y(bs_row);
			step.col         = bs_col;
			step.row         = bs_row;
		end else if (!glyph_pending && adv_scroll) begin
			// scroll now, glyph on the next step
			step.emit          = 1'b1;
			step.res.command   = CMD_SCROLL;
			step.col           = adv_col;
			step.row           = adv_row_c;
			step.glyph_pending = 1'b1;
		end else begin
			step.emit           = 1'b1;
			step.done           = !is_tab || last_space;
			step.next_space     = is_tab;
			step.res.command    = CMD_GLYPH;
			step.res.pixel_x    = pix_x(g_col);
			step.res.pixel_y    = pix_y(g_row);
			step.res.glyph_code = is_tab ? CHAR_SPACE : item.char_code;
			step.res.draw_color = item.fg_color;
			step.col            = g_col;
			step.row            = g_row;
		end
	end

endmodule

FILE: hdl/text_console_cursor_engine_unit.sv
// Top level of the text console cursor engine: handshakes, cursor state and sequencer.
//
// Each input word is held in an item register and worked off one step per clock while the
// output side keeps up; every step gives at most one command word, which goes to an output
// register. When the cursor advance of an ordinary character scrolls, the scroll gets a step
// of its own before the glyph; a tab draws TAB_SPACES spaces, and a backspace at column zero
// is drawn like an ordinary character. A newline may give no word at all. At most eight
// words come from one input word (extra tab commands are dropped, the cursor still moves),
// and tlast marks the final one. The next input word is taken in the cycle the current one
// finishes, so ordinary characters without a scroll run at one per clock while the output
// side keeps up; steps that give no word proceed while a finished word waits in the output
// register. Configuration writes are taken at any time (cfg_ready is always high) but must
// only be made while the block is idle.
module text_console_cursor_engine_unit import tcce_pkg::*; #(
	parameter int TAB_SPACES = TAB_SPACES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [7:0] char_code, [31:8] fg_color
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [11:0] pixel_x, [23:12] pixel_y, [31:24] glyph_code,
	                               // [55:32] draw_color
	output logic [1:0]  m_tuser,   // [1:0] command
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int TabW = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;
	localparam int CntW = $clog2(MAX_RESULTS + 1);

	logic            busy_q;
	item_t           item_s1;
	logic            glyph_pending_q;
	logic [TabW-1:0] space_q;
	logic [CntW-1:0] count_q;
	logic [8:0]      col_q;
	logic [7:0]      row_q;
	logic [7:0]      cols_q;
	logic [7:0]      rows_q;
	logic [23:0]     bg_q;
	logic            out_valid_q;
	result_t         out_s2;
	logic            out_last_s2;

	step_t           step;
	logic            last_space;
	logic            out_emit;
	logic            out_last;
	logic            fire;
	logic            accept;

	tcce_step u_step (
		.item             (item_s1),
		.glyph_pending    (glyph_pending_q),
		.last_space       (last_space),
		.col              (col_q),
		.row              (row_q),
		.text_columns     (cols_q),
		.text_rows        (rows_q),
		.background_color (bg_q),
		.step             (step)
	);

	assign last_space = (space_q == TabW'(TAB_SPACES - 1));
	// results past the per-word limit are dropped
	assign out_emit   = step.emit && (count_q < CntW'(MAX_RESULTS));
	assign out_last   = step.done || (count_q == CntW'(MAX_RESULTS - 1));
	assign fire       = busy_q && (!out_emit || !out_valid_q || m_tready);
	assign s_tready   = !busy_q || (fire && step.done);
	assign accept     = s_tvalid && s_tready;
	assign cfg_ready  = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_s2.draw_color, out_s2.glyph_code, out_s2.pixel_y, out_s2.pixel_x};
	assign m_tuser  = out_s2.command;
	assign m_tlast  = out_last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q          <= 1'b0;
			glyph_pending_q <= 1'b0;
			space_q         <= '0;
			count_q         <= '0;
			col_q           <= '0;
			row_q           <= '0;
			cols_q          <= CTRL_TEXT_COLUMNS;
			rows_q          <= CTRL_TEXT_ROWS;
			bg_q            <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				busy_q          <= 1'b1;
				glyph_pending_q <= 1'b0;
				space_q         <= '0;
				count_q         <= '0;
			end else if (fire) begin
				if (step.done) begin
					busy_q <= 1'b0;
				end
				glyph_pending_q <= step.glyph_pending;
				if (step.next_space) begin
					space_q <= space_q + TabW'(1);
				end
				if (out_emit) begin
					count_q <= count_q + CntW'(1);
				end
			end

			if (fire) begin
				col_q <= step.col;
				row_q <= step.row;
			end

			if (fire && out_emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				case (cfg_index)
					CFG_TEXT_COLUMNS:     cols_q <= cfg_data[7:0];
					CFG_TEXT_ROWS:        rows_q <= cfg_data[7:0];
					CFG_BACKGROUND_COLOR: bg_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode    <= s_tuser;
			item_s1.char_code <= s_tdata[7:0];
			item_s1.fg_color  <= s_tdata[31:8];
		end
		if (fire && out_emit) begin
			out_s2      <= step.res;
			out_last_s2 <= out_last;
		end
	end

endmodule

FILE: test/text_console_cursor_engine_unit_test.sv
// Self-checking testbench for the text console cursor engine: directed and random console words.
module text_console_cursor_engine_unit_test;
	import tcce_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 1_000_000;

	typedef struct {
		result_t cmd;
		logic    last;
	} cmd_word_t;

	// cursor tracking plus the queue of command words still owed by the block
	class console_command_board;
		logic [7:0]  columns;
		logic [7:0]  rows;
		logic [23:0] background;
		logic [8:0]  column;
		logic [7:0]  row;
		cmd_word_t   awaited[$];
		result_t     batch[$];
		int          errors;

		function new();
			columns    = CTRL_TEXT_COLUMNS;
			rows       = CTRL_TEXT_ROWS;
			background = '0;
			column     = '0;
			row        = '0;
			errors     = 0;
		endfunction

		function void apply_reg(cfg_reg_t idx, logic [23:0] value);
			case (idx)
				CFG_TEXT_COLUMNS: begin
					columns = value[7:0];
				end
				CFG_TEXT_ROWS: begin
					rows = value[7:0];
				end
				CFG_BACKGROUND_COLOR: begin
					background = value;
				end
				default: begin
				end
			endcase
		endfunction

		// commands past the per-word limit are dropped, the cursor still moves
		function void add_cmd(cmd_t c, int px, int py, logic [7:0] glyph, logic [23:0] colour);
			result_t r;
			if (batch.size() >= MAX_RESULTS)
				return;
			r.command    = c;
			r.pixel_x    = px[11:0];
			r.pixel_y    = py[11:0];
			r.glyph_code = glyph;
			r.draw_color = colour;
			batch.push_back(r);
		endfunction

		function void advance();
			if (column > {1'b0, columns}) begin
				column = '0;
				row    = row + 8'd1;
			end else begin
				column = column + 9'd1;
			end
			if (row >= rows) begin
				row = (rows != 8'd0) ? rows - 8'd1 : 8'd0;
				add_cmd(CMD_SCROLL, 0, 0, 8'd0, background);
			end
		endfunction

		function void put_glyph(logic [7:0] code, logic [23:0] colour);
			advance();
			add_cmd(CMD_GLYPH, int'(column) * GLYPH_WIDTH - GLYPH_X_OFFSET,
				int'(row) * GLYPH_HEIGHT, code, colour);
		endfunction

		function void absorb_item(item_t it);
			cmd_word_t w;
			batch.delete();
			if (it.opcode == OP_CLEAR_SCREEN) begin
				add_cmd(CMD_FILL, 0, 0, 8'd0, background);
				column = '0;
				row    = '0;
			end else if (it.char_code == CHAR_NEWLINE) begin
				advance();
				column = '0;
				row    = row + 8'd1;
			end else if (it.char_code == CHAR_RETURN) begin
				column = '0;
			end else if (it.char_code == CHAR_TAB) begin
				for (int i = 0; i < TAB_SPACES_DEF; i++)
					put_glyph(CHAR_SPACE, it.fg_color);
			end else if (it.char_code == CHAR_BACKSPACE && column != 9'd0) begin
				column = column - 9'd1;
				if (column == 9'd0) begin
					column = (columns != 8'd0) ? {1'b0, columns} - 9'd1 : 9'd0;
					if (row != 8'd0)
						row = row - 8'd1;
					// back on the top row: home the cursor
					if (row == 8'd0) begin
						column = '0;
						row    = '0;
					end
				end
				add_cmd(CMD_CLEAR, (int'(column) + 1) * GLYPH_WIDTH - GLYPH_X_OFFSET,
					int'(row) * GLYPH_HEIGHT, 8'd0, background);
			end else begin
				// includes backspace at column zero, drawn as a glyph
				put_glyph(it.char_code, it.fg_color);
			end
			foreach (batch[i]) begin
				w.cmd  = batch[i];
				w.last = (i == batch.size() - 1);
				awaited.push_back(w);
			end
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_word(result_t got, logic got_last);
			cmd_word_t w;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected word cmd=%0d x=%0d y=%0d", got.command,
					got.pixel_x, got.pixel_y));
				return;
			end
			w = awaited.pop_front();
			if (got.command !== w.cmd.command)
				report($sformatf("command %0d, want %0d", got.command, w.cmd.command));
			if (got.pixel_x !== w.cmd.pixel_x)
				report($sformatf("pixel_x %0d, want %0d", got.pixel_x, w.cmd.pixel_x));
			if (got.pixel_y !== w.cmd.pixel_y)
				report($sformatf("pixel_y %0d, want %0d", got.pixel_y, w.cmd.pixel_y));
			if (got.glyph_code !== w.cmd.glyph_code)
				report($sformatf("glyph %0h, want %0h", got.glyph_code, w.cmd.glyph_code));
			if (got.draw_color !== w.cmd.draw_color)
				report($sformatf("colour %h, want %h", got.draw_color, w.cmd.draw_color));
			if (got_last !== w.last)
				report($sformatf("tlast %b, want %b", got_last, w.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	console_command_board board = new();
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;

	text_console_cursor_engine_unit u_top (.*);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			board.absorb_item(item_t'{s_tuser, s_tdata[7:0], s_tdata[31:8]});
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_word(result_t'{cmd_t'(m_tuser), m_tdata[11:0], m_tdata[23:12],
				m_tdata[31:24], m_tdata[55:32]}, m_tlast);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("text_console_cursor_engine_unit_test: FAIL");
			$finish;
		end
	end

	task send_item(logic op, logic [7:0] ch, logic [23:0] fg);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {fg, ch};
		do @(posedge clk); while (!s_tready);
	endtask

	task set_register(cfg_reg_t idx, logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.apply_reg(idx, value);
	endtask

	// wait until every owed word is in, then let a silent newline or return settle
	task drain();
		s_tvalid <= 1'b0;
		// the last accepted word is noted by the board at the edge just passed
		@(posedge clk);
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// control codes and glyphs mixed so the cursor wraps, scrolls and backs up
	task send_random(int count);
		logic       op;
		logic [7:0] ch;
		int         pick;
		repeat (count) begin
			pick = $urandom_range(99);
			op   = OP_PUT_CHAR;
			ch   = 8'($urandom_range(255));
			if (pick < 8)
				op = OP_CLEAR_SCREEN;
			else if (pick < 18)
				ch = CHAR_NEWLINE;
			else if (pick < 24)
				ch = CHAR_RETURN;
			else if (pick < 32)
				ch = CHAR_TAB;
			else if (pick < 48)
				ch = CHAR_BACKSPACE;
			send_item(op, ch, 24'($urandom));
		end
	endtask

	task run_phase(int idle, int stall, logic [7:0] cols, logic [7:0] nrows,
			logic [23:0] bg, int count);
		drain();
		set_register(CFG_TEXT_COLUMNS, {16'd0, cols});
		set_register(CFG_TEXT_ROWS, {16'd0, nrows});
		set_register(CFG_BACKGROUND_COLOR, bg);
		cfg_valid      <= 1'b0;
		send_idle_pct  = idle;
		recv_stall_pct <= stall;
		send_random(count);
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_PUT_CHAR;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_TEXT_COLUMNS;
		cfg_data  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tiny screen so wrap and scroll come quickly
		set_register(CFG_TEXT_COLUMNS, 24'd3);
		set_register(CFG_TEXT_ROWS, 24'd2);
		set_register(CFG_BACKGROUND_COLOR, 24'($urandom));
		cfg_valid <= 1'b0;
		send_item(OP_CLEAR_SCREEN, 8'hFF, 24'hFFFFFF);
		send_item(OP_PUT_CHAR, CHAR_BACKSPACE, 24'h000000);
		send_item(OP_PUT_CHAR, 8'h41, 24'h000000);
		send_item(OP_PUT_CHAR, 8'h00, 24'hFFFFFF);
		send_item(OP_PUT_CHAR, 8'hFF, 24'h123456);
		send_item(OP_PUT_CHAR, 8'h42, 24'hA5A5A5);
		send_item(OP_PUT_CHAR, CHAR_TAB, 24'h5A5A5A);
		send_item(OP_PUT_CHAR, CHAR_TAB, 24'hFFFFFF);
		send_item(OP_PUT_CHAR, CHAR_NEWLINE, 24'h000000);
		send_item(OP_PUT_CHAR, CHAR_NEWLINE, 24'h000000);
		send_item(OP_PUT_CHAR, 8'h43, 24'h00FF00);
		send_item(OP_PUT_CHAR, CHAR_RETURN, 24'h000000);
		send_item(OP_PUT_CHAR, CHAR_BACKSPACE, 24'hFF0000);
		send_item(OP_PUT_CHAR, CHAR_BACKSPACE, 24'h0000FF);
		send_item(OP_PUT_CHAR, 8'h44, 24'h808080);
		send_item(OP_PUT_CHAR, 8'h45, 24'h7F7F7F);
		send_item(OP_PUT_CHAR, CHAR_BACKSPACE, 24'h000000);
		send_item(OP_PUT_CHAR, CHAR_BACKSPACE, 24'h000000);
		send_item(OP_CLEAR_SCREEN, CHAR_NEWLINE, 24'h000000);
		send_item(OP_PUT_CHAR, CHAR_NEWLINE, 24'hFFFFFF);
		send_item(OP_PUT_CHAR, CHAR_BACKSPACE, 24'h00FFFF);
		send_item(OP_PUT_CHAR, CHAR_NEWLINE, 24'h000000);
		send_item(OP_PUT_CHAR, 8'h46, 24'hFF00FF);
		send_item(OP_PUT_CHAR, CHAR_BACKSPACE, 24'h000000);

		run_phase(0, 0, 8'd80, 8'd25, 24'($urandom), 55);
		run_phase(86, 0, 8'd1, 8'd1, 24'hFFFFFF, 55);
		run_phase(0, 86, 8'd255, 8'd255, 24'h000000, 55);
		run_phase(15, 15, 8'd1, 8'd255, 24'($urandom), 55);
		run_phase(0, 0, 8'd255, 8'd1, 24'($urandom), 55);
		run_phase(86, 0, 8'd5, 8'd4, 24'($urandom), 55);
		run_phase(0, 86, 8'd12, 8'd3, 24'($urandom), 55);
		run_phase(15, 15, 8'd2, 8'd7, 24'($urandom), 55);
		drain();

		if (board.awaited.size() != 0)
			board.report($sformatf("%0d words never arrived", board.awaited.size()));
		if (board.errors == 0) begin
			$display("text_console_cursor_engine_unit_test: PASS");
		end else begin
			$display("text_console_cursor_engine_unit_test: FAIL");
		end
		$finish;
	end

endmodule
